@@ design/dhp_pkg.sv @@
package dhp_pkg;

    // Parse phases, one-hot
    typedef enum logic [6:0] {
        PH_FLOW = 7'b0000001,
        PH_FLAG = 7'b0000010,
        PH_MSG  = 7'b0000100,
        PH_IDX  = 7'b0001000,
        PH_CNT  = 7'b0010000,
        PH_PAY  = 7'b0100000,
        PH_ERR  = 7'b1000000
    } t_phase;

    // Frame status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_VARINT = 2'd1,
        ST_FLAG   = 2'd2
    } t_status;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_FLAG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_FLAG   = 1'd1;

    localparam logic [7:0] PLAIN_FLAG_RESET = 8'd0;
    localparam logic [7:0] SEG_FLAG_RESET   = 8'd1;

    // Varint limits: index of the last byte allowed
    localparam logic [3:0] V32_LAST_BYTE = 4'd4;
    localparam logic [3:0] V64_LAST_BYTE = 4'd9;

    localparam int unsigned LEN_W      = 12;
    localparam int unsigned LEN_HW_MAX = 4095;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // Output stream packing
    localparam int unsigned OUT_TDATA_W = 152;

    // One datagram byte after classification
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       cont;
    } t_item;

    // One result item
    typedef struct packed {
        logic              payload_valid;
        logic [7:0]        payload_byte;
        logic              frame_done;
        t_status           status;
        logic [31:0]       flow_id;
        logic              is_segmented;
        logic [63:0]       msg_ident;
        logic [15:0]       seg_number;
        logic [15:0]       seg_total;
        logic [LEN_W-1:0]  payload_length;
    } t_result;

endpackage

@@ design/dhp_front.sv @@
module dhp_front
    import dhp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output logic       o_ready,
    output logic       o_valid,
    output t_item      o_item,
    input  logic       i_ready
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Tag each byte with its continuation bit
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.data <= i_data;
            r_item.last <= i_last;
            r_item.cont <= i_data[7];
        end
    end

endmodule

@@ design/dhp_queue.sv @@
module dhp_queue
    import dhp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_item i_push_item,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_item o_pop_item,
    input  logic  i_pop_ready
);

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QPTR_W:0]   FULL_CNT = (QPTR_W + 1)'(QUEUE_DEPTH);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

@@ design/dhp_back.sv @@
module dhp_back
    import dhp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    input  t_item      i_item,
    output logic       o_item_ready,
    input  logic [7:0] i_plain_code,
    input  logic [7:0] i_seg_code,
    output logic       o_valid,
    output t_result    o_result,
    input  logic       i_ready
);

    localparam int CAP_INT = (MAX_FRAME_BYTES < LEN_HW_MAX) ? MAX_FRAME_BYTES : LEN_HW_MAX;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_INT);

    t_phase           r_phase,   n_phase;
    logic [63:0]      r_acc,     n_acc;
    logic [3:0]       r_vcount,  n_vcount;
    logic [31:0]      r_flow,    n_flow;
    logic [63:0]      r_msg,     n_msg;
    logic [15:0]      r_index,   n_index;
    logic [15:0]      r_count,   n_count;
    logic             r_seg,     n_seg;
    t_status          r_err,     n_err;
    logic [LEN_W-1:0] r_pay_cnt, n_pay_cnt;
    logic             r_out_valid;
    t_result          r_out,     n_out;

    logic        take;
    logic [5:0]  v_shift;
    logic [63:0] v_acc;
    logic [3:0]  v_last_byte;
    logic        v_bad;
    t_status     v_status;

    assign o_item_ready = !r_out_valid || i_ready;
    assign take         = i_item_valid && o_item_ready;
    assign o_valid      = r_out_valid;
    assign o_result     = r_out;

    // Shared varint step: place the low seven bits at 7 * byte count
    assign v_shift     = 6'({2'b00, r_vcount} * 6'd7);
    assign v_acc       = r_acc | ({57'd0, i_item.data[6:0]} << v_shift);
    assign v_last_byte = (r_phase == PH_MSG) ? V64_LAST_BYTE : V32_LAST_BYTE;
    assign v_bad       = i_item.cont && (r_vcount == v_last_byte);

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_vcount  = r_vcount;
        n_flow    = r_flow;
        n_msg     = r_msg;
        n_index   = r_index;
        n_count   = r_count;
        n_seg     = r_seg;
        n_err     = r_err;
        n_pay_cnt = r_pay_cnt;
        n_out     = '0;
        v_status  = ST_OK;

        case (r_phase)
            PH_FLOW, PH_MSG, PH_IDX, PH_CNT: begin
                if (!i_item.cont) begin
                    n_acc    = '0;
                    n_vcount = '0;
                    case (r_phase)
                        PH_FLOW: begin
                            n_flow  = v_acc[31:0];
                            n_phase = PH_FLAG;
                        end
                        PH_MSG: begin
                            n_msg   = v_acc;
                            n_phase = PH_IDX;
                        end
                        PH_IDX: begin
                            n_index = v_acc[15:0];
                            n_phase = PH_CNT;
                        end
                        default: begin
                            n_count = v_acc[15:0];
                            n_phase = PH_PAY;
                        end
                    endcase
                end else if (v_bad) begin
                    n_err    = ST_VARINT;
                    n_phase  = PH_ERR;
                    n_acc    = '0;
                    n_vcount = '0;
                end else begin
                    // Drop bits above the field width of 32-bit varints
                    n_acc    = (r_phase == PH_MSG) ? v_acc : {32'd0, v_acc[31:0]};
                    n_vcount = r_vcount + 4'd1;
                end
            end
            PH_FLAG: begin
                // Plain wins when both codes match
                if (i_item.data == i_plain_code) begin
                    n_seg   = 1'b0;
                    n_phase = PH_PAY;
                end else if (i_item.data == i_seg_code) begin
                    n_seg   = 1'b1;
                    n_phase = PH_MSG;
                end else begin
                    n_err    = ST_FLAG;
                    n_phase  = PH_ERR;
                    n_acc    = '0;
                    n_vcount = '0;
                end
            end
            PH_PAY: begin
                n_out.payload_valid = 1'b1;
                n_out.payload_byte  = i_item.data;
                if (r_pay_cnt < LEN_CAP) begin
                    n_pay_cnt = r_pay_cnt + 1'b1;
                end
            end
            PH_ERR: begin
                n_phase = PH_ERR;
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase

        if (i_item.last) begin
            case (n_phase)
                PH_ERR:                          v_status = n_err;
                PH_FLOW, PH_MSG, PH_IDX, PH_CNT: v_status = ST_VARINT;
                default:                         v_status = ST_OK;
            endcase
            n_out.frame_done = 1'b1;
            n_out.status     = v_status;
            if (v_status == ST_OK) begin
                n_out.flow_id        = n_flow;
                n_out.is_segmented   = n_seg;
                n_out.msg_ident      = n_msg;
                n_out.seg_number     = n_index;
                n_out.seg_total      = n_count;
                n_out.payload_length = n_pay_cnt;
            end
            // Start over for the next datagram
            n_phase   = PH_FLOW;
            n_acc     = '0;
            n_vcount  = '0;
            n_flow    = '0;
            n_msg     = '0;
            n_index   = '0;
            n_count   = '0;
            n_seg     = 1'b0;
            n_err     = ST_OK;
            n_pay_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FLOW;
            r_acc       <= '0;
            r_vcount    <= '0;
            r_flow      <= '0;
            r_msg       <= '0;
            r_index     <= '0;
            r_count     <= '0;
            r_seg       <= 1'b0;
            r_err       <= ST_OK;
            r_pay_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase   <= n_phase;
                r_acc     <= n_acc;
                r_vcount  <= n_vcount;
                r_flow    <= n_flow;
                r_msg     <= n_msg;
                r_index   <= n_index;
                r_count   <= n_count;
                r_seg     <= n_seg;
                r_err     <= n_err;
                r_pay_cnt <= n_pay_cnt;
            end
            if (o_item_ready) begin
                r_out_valid <= i_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

    a_err_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status != ST_OK) |->
            (r_out.flow_id == '0) && (r_out.msg_ident == '0) && (r_out.payload_length == '0))
        else $error("error result carries header fields");

    a_vcount_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MSG) ? (r_vcount <= V64_LAST_BYTE) : (r_vcount <= V32_LAST_BYTE))
        else $error("varint byte count past its limit");

    a_pay_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pay_cnt <= LEN_CAP)
        else $error("payload counter past its cap");

endmodule

@@ design/datagram_header_parser.sv @@
// Channel   Direction  Signals                                    Transfer when
// s_axis    in         tdata[7:0] data_byte, tlast last_byte      tvalid && tready
// m_axis    out        tdata header+payload, tuser, tlast         tvalid && tready
// cfg       in         index (0 plain flag, 1 segmented flag)     valid && ready
//
// One result per input byte; throughput is one byte per cycle while the output is not stalled.
// Each byte passes the front register, the two-entry queue and the result register.
// The parser state lives in a single back-end register set updated per byte.
// Reset is synchronous, active low; flag codes return to plain 0, segmented 1.
// A stalled output holds the result; the queue absorbs the front until full.
module datagram_header_parser
    import dhp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input bytes
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,  // [7:0] data_byte
    input  logic                   i_s_axis_tlast,  // last_byte
    // Results
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [7:0] payload_byte, [9:8] status, [41:10] flow_id, [42] is_segmented,
    // [106:43] msg_ident, [122:107] seg_number, [138:123] seg_total,
    // [150:139] payload_length, [151] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                   o_m_axis_tuser,  // payload_valid
    output logic                   o_m_axis_tlast,  // frame_done
    // Configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]             i_cfg_data
);

    logic [7:0] r_plain_code;
    logic [7:0] r_seg_code;

    logic    front_valid;
    t_item   front_item;
    logic    front_ready;
    logic    q_valid;
    t_item   q_item;
    logic    q_ready;
    t_result result;

    // Flag codes: writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plain_code <= PLAIN_FLAG_RESET;
            r_seg_code   <= SEG_FLAG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PLAIN_FLAG: r_plain_code <= i_cfg_data;
                CFG_SEG_FLAG:   r_seg_code   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Front: register and classify each incoming byte
    dhp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_ready (o_s_axis_tready),
        .o_valid (front_valid),
        .o_item  (front_item),
        .i_ready (front_ready)
    );

    // Decouple front and back so either can stall alone
    dhp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_item  (front_item),
        .o_push_ready (front_ready),
        .o_pop_valid  (q_valid),
        .o_pop_item   (q_item),
        .i_pop_ready  (q_ready)
    );

    // Back: parse header, pass payload, build the result
    dhp_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_item_ready (q_ready),
        .i_plain_code (r_plain_code),
        .i_seg_code   (r_seg_code),
        .o_valid      (o_m_axis_tvalid),
        .o_result     (result),
        .i_ready      (i_m_axis_tready)
    );

    // Pack the result, first field in the lowest bits
    assign o_m_axis_tdata = {1'b0,
                             result.payload_length,
                             result.seg_total,
                             result.seg_number,
                             result.msg_ident,
                             result.is_segmented,
                             result.flow_id,
                             result.status,
                             result.payload_byte};
    assign o_m_axis_tuser = result.payload_valid;
    assign o_m_axis_tlast = result.frame_done;

endmodule

@@ verif/dhp_frame_checker.sv @@
module dhp_frame_checker
    import dhp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    input  logic                   i_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,   // [7:0] data_byte
    input  logic                   i_s_axis_tlast,   // last_byte
    input  logic                   i_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_axis_tdata,   // same layout as the block's output
    input  logic                   i_m_axis_tuser,   // payload_valid
    input  logic                   i_m_axis_tlast,   // frame_done
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]             i_cfg_data,
    output int                     o_pending,
    output int                     o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LENGTH_CAP =
        (MAX_FRAME_BYTES < LEN_HW_MAX) ? MAX_FRAME_BYTES : LEN_HW_MAX;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        GROUP_MORE,
        GROUP_END,
        GROUP_OVERRUN
    } t_group;

    // Predicted parser state and flag codes
    logic [7:0]       plain_code;
    logic [7:0]       seg_code;
    t_phase           hdr_phase;
    logic [63:0]      group_acc;
    logic [3:0]       group_cnt;
    logic [31:0]      flow_q;
    logic [63:0]      msg_q;
    logic [15:0]      idx_q;
    logic [15:0]      cnt_q;
    logic             seg_q;
    t_status          err_q;
    logic [LEN_W-1:0] len_q;

    t_result byte_outcomes[$];
    int      result_no;

    function automatic void restart_varint();
        group_acc = '0;
        group_cnt = '0;
    endfunction

    function automatic void clear_frame();
        hdr_phase = PH_FLOW;
        restart_varint();
        flow_q = '0;
        msg_q  = '0;
        idx_q  = '0;
        cnt_q  = '0;
        seg_q  = 1'b0;
        err_q  = ST_OK;
        len_q  = '0;
    endfunction

    function automatic void abort_frame(input t_status code);
        err_q     = code;
        hdr_phase = PH_ERR;
        restart_varint();
    endfunction

    // Fold one LEB128 group in; a narrow varint drops everything above bit 31
    function automatic t_group absorb_group(input logic [7:0] b, input logic [3:0] last_idx,
                                            input logic wide);
        group_acc = group_acc | (64'(b[6:0]) << (7 * group_cnt));
        if (!wide)
            group_acc[63:32] = '0;
        if (!b[7])
            return GROUP_END;
        if (group_cnt == last_idx)
            return GROUP_OVERRUN;
        group_cnt++;
        return GROUP_MORE;
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b, input logic last);
        t_result r;
        t_group  g;
        r = '0;
        case (hdr_phase)
            PH_FLOW: begin
                g = absorb_group(b, V32_LAST_BYTE, 1'b0);
                if (g == GROUP_OVERRUN) begin
                    abort_frame(ST_VARINT);
                end else if (g == GROUP_END) begin
                    flow_q = group_acc[31:0];
                    restart_varint();
                    hdr_phase = PH_FLAG;
                end
            end
            PH_FLAG: begin
                // plain wins when both codes are equal
                if (b == plain_code) begin
                    seg_q = 1'b0;
                    hdr_phase = PH_PAY;
                end else if (b == seg_code) begin
                    seg_q = 1'b1;
                    hdr_phase = PH_MSG;
                end else begin
                    abort_frame(ST_FLAG);
                end
            end
            PH_MSG: begin
                g = absorb_group(b, V64_LAST_BYTE, 1'b1);
                if (g == GROUP_OVERRUN) begin
                    abort_frame(ST_VARINT);
                end else if (g == GROUP_END) begin
                    msg_q = group_acc;
                    restart_varint();
                    hdr_phase = PH_IDX;
                end
            end
            PH_IDX: begin
                g = absorb_group(b, V32_LAST_BYTE, 1'b0);
                if (g == GROUP_OVERRUN) begin
                    abort_frame(ST_VARINT);
                end else if (g == GROUP_END) begin
                    idx_q = group_acc[15:0];
                    restart_varint();
                    hdr_phase = PH_CNT;
                end
            end
            PH_CNT: begin
                g = absorb_group(b, V32_LAST_BYTE, 1'b0);
                if (g == GROUP_OVERRUN) begin
                    abort_frame(ST_VARINT);
                end else if (g == GROUP_END) begin
                    cnt_q = group_acc[15:0];
                    restart_varint();
                    hdr_phase = PH_PAY;
                end
            end
            PH_PAY: begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                if (len_q < LENGTH_CAP)
                    len_q++;
            end
            default: ;
        endcase

        if (last) begin
            r.frame_done = 1'b1;
            case (hdr_phase)
                PH_ERR:                         r.status = err_q;
                PH_FLOW, PH_MSG, PH_IDX, PH_CNT: r.status = ST_VARINT;
                default:                        r.status = ST_OK;
            endcase
            if (r.status == ST_OK) begin
                r.flow_id        = flow_q;
                r.is_segmented   = seg_q;
                r.msg_ident      = msg_q;
                r.seg_number     = idx_q;
                r.seg_total      = cnt_q;
                r.payload_length = len_q;
            end
            clear_frame();
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            o_mismatches++;
            if (o_mismatches <= MAX_REPORTS)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         result_no, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            plain_code = PLAIN_FLAG_RESET;
            seg_code   = SEG_FLAG_RESET;
            clear_frame();
            byte_outcomes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PLAIN_FLAG: plain_code = i_cfg_data;
                    CFG_SEG_FLAG:   seg_code   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                byte_outcomes.push_back(parse_byte(i_s_axis_tdata, i_s_axis_tlast));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                result_no++;
                got.payload_valid  = i_m_axis_tuser;
                got.payload_byte   = i_m_axis_tdata[7:0];
                got.frame_done     = i_m_axis_tlast;
                got.status         = t_status'(i_m_axis_tdata[9:8]);
                got.flow_id        = i_m_axis_tdata[41:10];
                got.is_segmented   = i_m_axis_tdata[42];
                got.msg_ident      = i_m_axis_tdata[106:43];
                got.seg_number     = i_m_axis_tdata[122:107];
                got.seg_total      = i_m_axis_tdata[138:123];
                got.payload_length = i_m_axis_tdata[150:139];
                if (byte_outcomes.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= MAX_REPORTS)
                        $display("result %0d: transfer with no byte waiting for it", result_no);
                end else begin
                    want = byte_outcomes.pop_front();
                    compare_field("payload_valid", 64'(want.payload_valid),
                                  64'(got.payload_valid));
                    compare_field("payload_byte", 64'(want.payload_byte),
                                  64'(got.payload_byte));
                    compare_field("frame_done", 64'(want.frame_done), 64'(got.frame_done));
                    compare_field("status", 64'(want.status), 64'(got.status));
                    compare_field("flow_id", 64'(want.flow_id), 64'(got.flow_id));
                    compare_field("is_segmented", 64'(want.is_segmented),
                                  64'(got.is_segmented));
                    compare_field("msg_ident", want.msg_ident, got.msg_ident);
                    compare_field("seg_number", 64'(want.seg_number), 64'(got.seg_number));
                    compare_field("seg_total", 64'(want.seg_total), 64'(got.seg_total));
                    compare_field("payload_length", 64'(want.payload_length),
                                  64'(got.payload_length));
                end
            end
        end
        o_pending = byte_outcomes.size();
    end

endmodule

@@ verif/tb_datagram_header_parser.sv @@
module tb_datagram_header_parser
    import dhp_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAX_FRAME_BYTES = 2048;
    localparam int          HALF_PERIOD     = 2;
    localparam int          RESET_CYCLES    = 6;
    localparam int          N_SETTINGS      = 6;
    localparam int          RANDOM_BYTES    = 1850;
    localparam int          LONG_HOLD       = 200;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          CYCLE_LIMIT     = 600000;
    localparam int unsigned V32_BYTES       = int'(V32_LAST_BYTE) + 1;
    localparam int unsigned V64_BYTES       = int'(V64_LAST_BYTE) + 1;

    typedef enum {
        FR_SEGMENTED,
        FR_PLAIN,
        FR_FLOW_ONLY,
        FR_TRUNCATED,
        FR_OVERRUN,
        FR_BAD_FLAG,
        FR_NOISE
    } t_frame_kind;

    // Header field that gets an overlong varint
    typedef enum {
        AT_FLOW,
        AT_MSG,
        AT_IDX,
        AT_CNT,
        AT_NONE
    } t_overrun_at;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [7:0]             cfg_data;

    int pending;
    int mismatches;
    int cycle_count;
    int bytes_sent;
    int frames_sent;

    // Flag codes as last written, used to build well-formed frames
    logic [7:0] plain_code;
    logic [7:0] seg_code;

    logic       src_idle_on;
    logic       sink_idle_on;
    logic       hold_req;
    logic [7:0] frame_q[$];

    datagram_header_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    dhp_frame_checker #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .i_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_pending       (pending),
        .o_mismatches    (mismatches)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Bail out if the handshakes hang
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request so
    // the block backs up all the way to its input
    initial begin : result_sink
        int  stall_left;
        int  hold_left;
        logic rdy;
        stall_left = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            rdy = 1'b1;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                rdy = 1'b0;
            end
            m_tready <= rdy;
        end
    end

    // Offer one byte, optionally after an idle burst; return right after the
    // transfer edge with tvalid still high
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    // Drop tvalid and hold until every predicted result has come back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_codes(input logic [7:0] plain, input logic [7:0] seg);
        write_reg(CFG_PLAIN_FLAG, plain);
        write_reg(CFG_SEG_FLAG, seg);
        plain_code = plain;
        seg_code   = seg;
    endtask

    // Append a LEB128 varint with random groups; an overrun keeps the
    // continuation bit set through the last allowed byte
    function automatic void add_varint(input int unsigned max_bytes, input logic overrun);
        int unsigned n;
        logic [6:0]  grp;
        logic        cont;
        n = overrun ? max_bytes : $urandom_range(1, max_bytes);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
                0:       grp = 7'h7F;
                1:       grp = 7'h00;
                default: grp = 7'($urandom);
            endcase
            cont = (i < n - 1) || overrun;
            frame_q.push_back({cont, grp});
        end
    endfunction

    // Bytes after an error, which the block must ignore
    function automatic void add_trailing();
        repeat ($urandom_range(0, 6)) frame_q.push_back(8'($urandom));
    endfunction

    function automatic void build_frame();
        t_frame_kind kind;
        t_overrun_at over_at;
        int unsigned roll;
        int unsigned cut;
        logic        segmented;
        logic [7:0]  flag;
        roll = $urandom_range(0, 99);
        kind = roll < 35 ? FR_SEGMENTED :
               roll < 60 ? FR_PLAIN     :
               roll < 65 ? FR_FLOW_ONLY :
               roll < 80 ? FR_TRUNCATED :
               roll < 88 ? FR_OVERRUN   :
               roll < 94 ? FR_BAD_FLAG  : FR_NOISE;
        frame_q.delete();
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
            return;
        end
        segmented = (kind == FR_SEGMENTED) ||
                    ((kind == FR_TRUNCATED || kind == FR_OVERRUN) &&
                     $urandom_range(0, 1) == 1);
        over_at = AT_NONE;
        if (kind == FR_OVERRUN)
            over_at = segmented ? t_overrun_at'($urandom_range(0, 3)) : AT_FLOW;

        add_varint(V32_BYTES, over_at == AT_FLOW);
        if (over_at == AT_FLOW) begin
            add_trailing();
            return;
        end
        if (kind == FR_FLOW_ONLY)
            return;
        if (kind == FR_BAD_FLAG) begin
            flag = 8'($urandom);
            while (flag == plain_code || flag == seg_code)
                flag++;
            frame_q.push_back(flag);
            add_trailing();
            return;
        end

        frame_q.push_back(segmented ? seg_code : plain_code);
        if (segmented) begin
            for (int f = AT_MSG; f <= AT_CNT; f++) begin
                add_varint(f == AT_MSG ? V64_BYTES : V32_BYTES, over_at == f);
                if (over_at == f) begin
                    add_trailing();
                    return;
                end
            end
        end
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(9, 40) : $urandom_range(0, 8))
            frame_q.push_back(8'($urandom));

        // Cut the datagram short anywhere, mostly inside the header
        if (kind == FR_TRUNCATED) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut)
                void'(frame_q.pop_back());
        end
    endfunction

    initial begin : stimulus
        int phase_end;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_PLAIN_FLAG;
        cfg_data     = '0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_req     = 1'b0;
        plain_code   = PLAIN_FLAG_RESET;
        seg_code     = SEG_FLAG_RESET;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int setting = 0; setting < N_SETTINGS; setting++) begin
            // Codes change only with the block idle; the first setting runs
            // on the reset codes
            case (setting)
                0:       ;
                1:       set_codes(8'hFF, 8'h00);
                2:       set_codes(8'h00, 8'hFF);
                3:       set_codes(8'h5A, 8'h5A);   // equal codes: plain must win
                default: set_codes(8'($urandom), 8'($urandom));
            endcase
            src_idle_on  = (setting != N_SETTINGS - 1) && (setting != 1);
            sink_idle_on = (setting != N_SETTINGS - 1) && (setting != 3);

            if (setting == 0) begin
                // Shortest datagram: flow id 0 only
                frame_q = '{8'h00};
                send_frame();
                // Five-byte flow id with the bits above 32 dropped
                frame_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
                send_frame();
                // Overlong flow id, then a byte that must be ignored
                frame_q = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00};
                send_frame();
                // Plain frame with two payload bytes
                frame_q = '{8'h01, PLAIN_FLAG_RESET, 8'hAA, 8'h55};
                send_frame();
                // Unknown flag byte
                frame_q = '{8'h02, 8'h07, 8'h33};
                send_frame();
                // Segmented frame with an empty payload
                frame_q = '{8'h7F, SEG_FLAG_RESET, 8'h80, 8'h01, 8'h05, 8'h03};
                send_frame();
            end

            // Long hold-off on the result side while bytes keep coming
            if (setting == 2)
                hold_req = 1'b1;

            phase_end = bytes_sent + RANDOM_BYTES / N_SETTINGS;
            while (bytes_sent < phase_end) begin
                build_frame();
                send_frame();
            end

            drain();
            repeat (4) @(negedge clk);
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d bytes in %0d datagrams over %0d flag code settings,",
                 bytes_sent, frames_sent, N_SETTINGS);
        $display("including overlong, truncated and bad-flag frames; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
